[hw/rtl/ckfr_pkg.sv]
// Shared types and constants of the checksummed frame receiver.
package ckfr_pkg;

	localparam int PLEN_W = 6;
	localparam int MIN_FRAME_BYTES = 5;
	localparam logic [PLEN_W-1:0] PAYLOAD_CAP = 6'd59;

	localparam logic [1:0] CFG_MAX_PAYLOAD_LEN = 2'd0;
	localparam logic [1:0] CFG_START_CODE = 2'd1;
	localparam logic [1:0] CFG_END_CODE = 2'd2;

	typedef enum logic [1:0] {
		ST_OK,
		ST_TIMEOUT,
		ST_MALFORMED,
		ST_BAD_SUM
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SEND
	} state_t;

endpackage

[hw/rtl/ckfr_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module ckfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/checksummed_frame_receiver_top.sv]
// Frame receiver top level: buffers UART bytes, checks start, end and sum, delivers the frame.
//
// Each received byte or timeout item is taken when in_stall is low; a byte in mid-frame gives no
// result; a timeout, a bad frame or a good frame with no payload gives one result at once. A
// good frame with payload starts a drain from the frame store: the first read of the store's
// read port is issued in S_READ, then one payload byte per cycle (at most 59) goes out while
// out_stall lets it, and input is held off until the last payload byte is loaded. A result waiting in
// the output register that is taken in the same cycle does not hold off input. The frame
// store needs no clearing after reset: only bytes written in the current frame are read.
module checksummed_frame_receiver_top #(
	parameter int FRAME_BUFFER_BYTES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic [7:0]        rx_byte,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	output logic              out_valid,
	input  logic              out_stall,
	output ckfr_pkg::status_t status,
	output logic [7:0]        cmd_first,
	output logic [7:0]        cmd_second,
	output logic [7:0]        data_byte,
	output logic              data_valid,
	output logic [5:0]        data_len,
	output logic              send_ack,
	output logic              last
);

	import ckfr_pkg::*;

	localparam int AW = $clog2(FRAME_BUFFER_BYTES);
	localparam int CW = $clog2(FRAME_BUFFER_BYTES + 1);
	localparam int LW = (CW > PLEN_W) ? CW : PLEN_W;

	state_t state_q, state_d;

	logic [CW-1:0]     count_q;
	logic [7:0]        sum_q;
	logic [7:0]        prev_q;
	logic [7:0]        first_q;
	logic [7:0]        cmd0_q;
	logic [7:0]        cmd1_q;
	logic [PLEN_W-1:0] plen_q;
	logic [PLEN_W-1:0] idx_q;
	logic [AW-1:0]     rd_addr_q;
	logic [PLEN_W-1:0] maxlen_q;
	logic [7:0]        start_q;
	logic [7:0]        end_q;

	logic              out_valid_q;
	status_t           status_q;
	logic [7:0]        cmd_first_q;
	logic [7:0]        cmd_second_q;
	logic [7:0]        data_byte_q;
	logic              data_valid_q;
	logic [PLEN_W-1:0] data_len_q;
	logic              send_ack_q;
	logic              last_q;

	logic              out_free;
	logic              accept;
	logic              byte_in;
	logic [CW-1:0]     total;
	logic              frame_end;
	logic              malformed;
	logic              bad_sum;
	logic [7:0]        expected;
	logic [PLEN_W-1:0] cap;
	logic [LW-1:0]     pl_full;
	logic [PLEN_W-1:0] plen;
	logic              last_byte;
	logic              rd_en;
	logic [7:0]        rd_data;

	logic              ld;
	status_t           ld_status;
	logic [7:0]        ld_c0;
	logic [7:0]        ld_c1;
	logic [7:0]        ld_data;
	logic              ld_dv;
	logic [PLEN_W-1:0] ld_plen;
	logic              ld_ack;
	logic              ld_last;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || !out_free;
	assign accept    = in_valid && !in_stall;
	assign byte_in   = accept && !action;
	assign cfg_ready = 1'b1;

	assign total     = count_q + CW'(1);
	assign frame_end = (rx_byte == end_q) || (total == CW'(FRAME_BUFFER_BYTES));
	assign expected  = sum_q - prev_q;
	assign bad_sum   = expected != prev_q;
	assign malformed = (LW'(total) < LW'(MIN_FRAME_BYTES)) || (first_q != start_q)
		|| (rx_byte != end_q);
	assign cap       = (maxlen_q > PAYLOAD_CAP) ? PAYLOAD_CAP : maxlen_q;
	assign pl_full   = LW'(total) - LW'(MIN_FRAME_BYTES);
	assign plen      = (pl_full > LW'(cap)) ? cap : pl_full[PLEN_W-1:0];
	assign last_byte = (idx_q + PLEN_W'(1)) == plen_q;
	assign rd_en     = (state_q == S_READ) || ((state_q == S_SEND) && out_free && !last_byte);

	ckfr_ram #(
		.WIDTH (8),
		.DEPTH (FRAME_BUFFER_BYTES)
	) u_frame_store (
		.clk     (clk),
		.wr_en   (byte_in),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (rx_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d   = state_q;
		ld        = 1'b0;
		ld_status = ST_OK;
		ld_c0     = 8'd0;
		ld_c1     = 8'd0;
		ld_data   = 8'd0;
		ld_dv     = 1'b0;
		ld_plen   = '0;
		ld_ack    = 1'b0;
		ld_last   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept && action) begin
					ld        = 1'b1;
					ld_status = ST_TIMEOUT;
				end else if (byte_in && frame_end) begin
					if (malformed) begin
						ld        = 1'b1;
						ld_status = ST_MALFORMED;
					end else if (bad_sum) begin
						ld        = 1'b1;
						ld_status = ST_BAD_SUM;
					end else if (plen == '0) begin
						ld     = 1'b1;
						ld_c0  = cmd0_q;
						ld_c1  = cmd1_q;
						ld_ack = 1'b1;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				state_d = S_SEND;
			end
			S_SEND: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_c0   = cmd0_q;
					ld_c1   = cmd1_q;
					ld_data = rd_data;
					ld_dv   = 1'b1;
					ld_plen = plen_q;
					ld_ack  = 1'b1;
					ld_last = last_byte;
					if (last_byte) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			sum_q       <= 8'd0;
			prev_q      <= 8'd0;
			plen_q      <= '0;
			idx_q       <= '0;
			rd_addr_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && action) begin
				count_q <= '0;
				sum_q   <= 8'd0;
				prev_q  <= 8'd0;
			end else if (byte_in) begin
				if (frame_end) begin
					count_q   <= '0;
					sum_q     <= 8'd0;
					prev_q    <= 8'd0;
					plen_q    <= plen;
					idx_q     <= '0;
					rd_addr_q <= AW'(3);
				end else begin
					count_q <= total;
					prev_q  <= rx_byte;
					if (count_q != '0) begin
						sum_q <= sum_q + rx_byte;
					end
				end
			end
			if (rd_en) begin
				rd_addr_q <= rd_addr_q + AW'(1);
			end
			if ((state_q == S_SEND) && out_free) begin
				idx_q <= idx_q + PLEN_W'(1);
			end
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxlen_q <= PLEN_W'(8);
			start_q  <= 8'd2;
			end_q    <= 8'd3;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAX_PAYLOAD_LEN: maxlen_q <= cfg_data[PLEN_W-1:0];
				CFG_START_CODE:      start_q  <= cfg_data;
				CFG_END_CODE:        end_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in) begin
			if (count_q == '0) begin
				first_q <= rx_byte;
			end
			if (count_q == CW'(1)) begin
				cmd0_q <= rx_byte;
			end
			if (count_q == CW'(2)) begin
				cmd1_q <= rx_byte;
			end
		end
		if (ld) begin
			status_q      <= ld_status;
			cmd_first_q   <= ld_c0;
			cmd_second_q  <= ld_c1;
			data_byte_q   <= ld_data;
			data_valid_q  <= ld_dv;
			data_len_q    <= ld_plen;
			send_ack_q    <= ld_ack;
			last_q        <= ld_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign cmd_first   = cmd_first_q;
	assign cmd_second  = cmd_second_q;
	assign data_byte   = data_byte_q;
	assign data_valid  = data_valid_q;
	assign data_len    = data_len_q;
	assign send_ack    = send_ack_q;
	assign last        = last_q;

endmodule

[hw/rtl/ckfr_checker.sv]
// Port-level assertions of the frame receiver and their bind to the top level.
module ckfr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input ckfr_pkg::status_t status,
	input logic [7:0]        cmd_first,
	input logic [7:0]        cmd_second,
	input logic [7:0]        data_byte,
	input logic              data_valid,
	input logic [5:0]        data_len,
	input logic              send_ack,
	input logic              last
);

	import ckfr_pkg::*;

	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> last && !send_ack && !data_valid
			&& (data_len == 6'd0) && (cmd_first == 8'd0) && (cmd_second == 8'd0)
			&& (data_byte == 8'd0))
		else $error("error result carries frame fields");

	a_ok_ack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OK) |-> send_ack && (data_valid || last))
		else $error("good frame result without ack");

	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && data_valid |-> (data_len != 6'd0) && (data_len <= PAYLOAD_CAP))
		else $error("payload byte with bad length");

	a_run_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input taken in the middle of a payload run");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(data_byte)
			&& $stable(last))
		else $error("stalled result changed");

endmodule

bind checksummed_frame_receiver_top ckfr_checker u_ckfr_checker (.*);

[verif/tb_checksummed_frame_receiver_top.sv]
// Testbench of the checksummed frame receiver: queued frame traffic, bursty driver, stalling monitor.
`timescale 1ns / 100ps

module tb_checksummed_frame_receiver_top;
	import ckfr_pkg::*;

	localparam int FRAME_BYTES = 64;
	localparam int PHASE_ITEMS = 64;
	localparam int IDLE_CYCLES = 100;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TIMEOUT = 1'b1;
	localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	typedef struct {
		logic       action;
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct {
		status_t    status;
		logic [7:0] cmd_first;
		logic [7:0] cmd_second;
		logic [7:0] data_byte;
		logic       data_valid;
		logic [5:0] data_len;
		logic       send_ack;
		logic       last;
	} frame_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       action = ACT_BYTE;
	logic [7:0] rx_byte = 8'h00;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = CFG_MAX_PAYLOAD_LEN;
	logic [7:0] cfg_data = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	status_t    status;
	logic [7:0] cmd_first;
	logic [7:0] cmd_second;
	logic [7:0] data_byte;
	logic       data_valid;
	logic [5:0] data_len;
	logic       send_ack;
	logic       last;

	rx_item_t      rx_items [$];
	frame_result_t frame_results_due [$];
	frame_result_t want_result;
	int            queued_count = 0;
	int            fail_count = 0;
	int            cycle_count = 0;
	int            burst_left = 0;
	int            gap_left = 0;
	stall_mode_t   stall_mode = STALL_NONE;
	int            mode_left = 0;
	int            stall_phase = 0;

	logic [7:0] frame_buf [FRAME_BYTES];
	int         buf_count;
	logic [7:0] buf_sum;
	logic [7:0] buf_prev;
	logic [5:0] max_len_reg;
	logic [7:0] start_reg;
	logic [7:0] end_reg;

	checksummed_frame_receiver_top #(
		.FRAME_BUFFER_BYTES(FRAME_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.rx_byte(rx_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.cmd_first(cmd_first),
		.cmd_second(cmd_second),
		.data_byte(data_byte),
		.data_valid(data_valid),
		.data_len(data_len),
		.send_ack(send_ack),
		.last(last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic clear_frame_state();
		buf_count = 0;
		buf_sum = 8'h00;
		buf_prev = 8'h00;
	endtask

	task automatic push_status(input status_t st);
		frame_result_t r;
		r.status = st;
		r.cmd_first = 8'h00;
		r.cmd_second = 8'h00;
		r.data_byte = 8'h00;
		r.data_valid = 1'b0;
		r.data_len = 6'd0;
		r.send_ack = 1'b0;
		r.last = 1'b1;
		frame_results_due.push_back(r);
	endtask

	task automatic predict_frame_item(input logic act, input logic [7:0] b);
		logic [7:0] sum_want;
		logic [7:0] prev_b;
		int total;
		int plen;
		int cap;
		frame_result_t r;
		if (act == ACT_TIMEOUT) begin
			clear_frame_state();
			push_status(ST_TIMEOUT);
		end else begin
			if (buf_count >= FRAME_BYTES)
				clear_frame_state();
			prev_b = buf_prev;
			sum_want = buf_sum - prev_b;
			frame_buf[buf_count] = b;
			if (buf_count >= 1)
				buf_sum = buf_sum + b;
			buf_prev = b;
			buf_count++;
			if (b == end_reg || buf_count >= FRAME_BYTES) begin
				total = buf_count;
				clear_frame_state();
				if (total < MIN_FRAME_BYTES || frame_buf[0] != start_reg || b != end_reg) begin
					push_status(ST_MALFORMED);
				end else if (sum_want != prev_b) begin
					push_status(ST_BAD_SUM);
				end else begin
					cap = (max_len_reg > PAYLOAD_CAP) ? int'(PAYLOAD_CAP) : int'(max_len_reg);
					plen = total - MIN_FRAME_BYTES;
					if (plen > cap)
						plen = cap;
					r.status = ST_OK;
					r.cmd_first = frame_buf[1];
					r.cmd_second = frame_buf[2];
					r.send_ack = 1'b1;
					if (plen == 0) begin
						r.data_byte = 8'h00;
						r.data_valid = 1'b0;
						r.data_len = 6'd0;
						r.last = 1'b1;
						frame_results_due.push_back(r);
					end else begin
						for (int i = 0; i < plen; i++) begin
							r.data_byte = frame_buf[3 + i];
							r.data_valid = 1'b1;
							r.data_len = 6'(plen);
							r.last = (i + 1 == plen);
							frame_results_due.push_back(r);
						end
					end
				end
			end
		end
	endtask

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		do begin
			case ($urandom_range(0, 7))
				0: b = 8'h00;
				1: b = 8'hFF;
				default: b = 8'($urandom_range(0, 255));
			endcase
		end while (b == end_reg);
		return b;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		rx_items.push_back('{ACT_BYTE, b});
		queued_count++;
	endtask

	task automatic push_timeout();
		rx_items.push_back('{ACT_TIMEOUT, 8'($urandom_range(0, 255))});
		queued_count++;
	endtask

	task automatic queue_frame(input logic [7:0] lead, input int plen, input logic [7:0] sum_err);
		logic [7:0] body [$];
		logic [7:0] chk;
		do begin
			body.delete();
			chk = sum_err;
			repeat (plen + 2) begin
				body.push_back(body_byte());
				chk = chk + body[$];
			end
		end while (chk == end_reg);
		push_byte(lead);
		foreach (body[i])
			push_byte(body[i]);
		push_byte(chk);
		push_byte(end_reg);
	endtask

	task automatic queue_random_traffic(input int budget);
		int stop_at;
		int r;
		int plen;
		int n;
		stop_at = queued_count + budget;
		while (queued_count < stop_at) begin
			r = $urandom_range(0, 99);
			plen = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 59) : $urandom_range(0, 10);
			if (r < 68) begin
				queue_frame(start_reg, plen, 8'h00);
			end else if (r < 76) begin
				queue_frame(start_reg, plen, 8'($urandom_range(1, 255)));
			end else if (r < 82) begin
				queue_frame(start_reg ^ 8'($urandom_range(1, 255)), plen, 8'h00);
			end else if (r < 87) begin
				n = $urandom_range(0, 3);
				if (n == 3) begin
					push_byte(end_reg);
				end else begin
					push_byte(start_reg);
					repeat (n) push_byte(body_byte());
					push_byte(end_reg);
				end
			end else if (r < 92) begin
				repeat ($urandom_range(0, 6)) push_byte(body_byte());
				push_timeout();
			end else if (r < 94) begin
				repeat (FRAME_BYTES) push_byte(body_byte());
			end else begin
				repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
				push_byte(end_reg);
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MAX_PAYLOAD_LEN: max_len_reg = data[5:0];
			CFG_START_CODE: start_reg = data;
			CFG_END_CODE: end_reg = data;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (rx_items.size() != 0 || frame_results_due.size() != 0 || in_valid);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_BYTE;
			rx_byte <= 8'h00;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_frame_item(action, rx_byte);
				void'(rx_items.pop_front());
			end
			if (in_valid && in_stall) begin
			end else if (gap_left > 0 || rx_items.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				in_valid <= 1'b1;
				action <= rx_items[0].action;
				rx_byte <= rx_items[0].rx_byte;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode = STALL_NONE;
			mode_left = 0;
			stall_phase = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (frame_results_due.size() == 0) begin
					$error("unexpected result: status %0d, data_byte %0d", status, data_byte);
					fail_count++;
				end else begin
					want_result = frame_results_due.pop_front();
					check_field("status", int'(want_result.status), int'(status));
					check_field("cmd_first", want_result.cmd_first, cmd_first);
					check_field("cmd_second", want_result.cmd_second, cmd_second);
					check_field("data_byte", want_result.data_byte, data_byte);
					check_field("data_valid", want_result.data_valid, data_valid);
					check_field("data_len", want_result.data_len, data_len);
					check_field("send_ack", want_result.send_ack, send_ack);
					check_field("last", want_result.last, last);
				end
			end
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			stall_phase++;
			case (stall_mode)
				STALL_NONE: out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (stall_phase % 3 == 0);
			endcase
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		clear_frame_state();
		max_len_reg = 6'd8;
		start_reg = 8'h02;
		end_reg = 8'h03;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		push_timeout();
		push_byte(8'h02); push_byte(8'hFF); push_byte(8'h00); push_byte(8'hFF); push_byte(8'h03);
		push_byte(8'h02); push_byte(8'h03);
		push_byte(8'hFF); push_byte(8'h01); push_byte(8'h01); push_byte(8'h02); push_byte(8'h03);
		push_byte(8'h02); push_byte(8'h01); push_byte(8'h01); push_byte(8'h05); push_byte(8'h03);
		push_byte(8'h02); push_byte(8'h01);
		push_timeout();
		push_byte(8'h02); push_byte(8'h80); push_byte(8'h01); push_byte(8'h7F);
		push_byte(8'h00); push_byte(8'h03);
		wait_idle();

		write_reg(CFG_MAX_PAYLOAD_LEN, 8'hC0);
		write_reg(CFG_START_CODE, 8'h00);
		write_reg(CFG_END_CODE, 8'hFF);
		queue_random_traffic(PHASE_ITEMS);
		wait_idle();

		write_reg(CFG_MAX_PAYLOAD_LEN, 8'h3F);
		write_reg(CFG_START_CODE, 8'hFF);
		write_reg(CFG_END_CODE, 8'h00);
		queue_random_traffic(PHASE_ITEMS);
		wait_idle();

		write_reg(CFG_MAX_PAYLOAD_LEN, 8'd59);
		write_reg(CFG_START_CODE, 8'hA5);
		write_reg(CFG_END_CODE, 8'h5A);
		queue_random_traffic(PHASE_ITEMS);
		wait_idle();

		write_reg(CFG_MAX_PAYLOAD_LEN, 8'($urandom_range(1, 12)));
		write_reg(CFG_START_CODE, 8'($urandom_range(0, 255)));
		write_reg(CFG_END_CODE, start_reg);
		write_reg(CFG_UNUSED_INDEX, 8'($urandom_range(0, 255)));
		queue_random_traffic(PHASE_ITEMS);
		wait_idle();

		write_reg(CFG_MAX_PAYLOAD_LEN, 8'($urandom_range(0, 255)));
		write_reg(CFG_START_CODE, 8'($urandom_range(0, 255)));
		write_reg(CFG_END_CODE, 8'($urandom_range(0, 255)));
		queue_random_traffic(PHASE_ITEMS);
		wait_idle();

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[checksummed_frame_receiver_top.f]
hw/rtl/ckfr_pkg.sv
hw/rtl/ckfr_ram.sv
hw/rtl/checksummed_frame_receiver_top.sv
hw/rtl/ckfr_checker.sv
verif/tb_checksummed_frame_receiver_top.sv
